[rtl/core/tpm_pkg.sv]
// Shared types and constants for the touch point mapper.
// No dependencies; imported by every module of the block.
`default_nettype none

package tpm_pkg;

   // Default panel and screen geometry.
   localparam int unsigned NativeWidthDef  = 320;
   localparam int unsigned NativeHeightDef = 480;
   localparam int unsigned ScreenWidthDef  = 480;
   localparam int unsigned ScreenHeightDef = 320;

   // Field widths.
   localparam int unsigned CoordWidth  = 9;
   localparam int unsigned RawWidth    = 12;
   localparam int unsigned LatchWidth  = 8;
   localparam int unsigned CsrData     = 32;
   localparam int unsigned CsrAddr     = 3;

   // Register map.
   localparam logic CsrIdxLatchPolls = 1'b0;
   localparam logic [LatchWidth-1:0] LatchPollsReset = 8'd5;

   // Point count limits taken from the low nibble of the status byte.
   localparam logic [3:0] PointCountMin = 4'd1;
   localparam logic [3:0] PointCountMax = 4'd2;

   // Mapped point for one poll.
   typedef struct packed {
      logic                  touched;
      logic [CoordWidth-1:0] x;
      logic [CoordWidth-1:0] y;
   } point_type;

endpackage

`default_nettype wire

[rtl/core/tpm_map.sv]
// Touch detection, clamping and landscape rotation of one poll word.
// Depends on tpm_pkg.
`default_nettype none

module tpm_map #(
   parameter int unsigned NATIVE_WIDTH  = tpm_pkg::NativeWidthDef,
   parameter int unsigned NATIVE_HEIGHT = tpm_pkg::NativeHeightDef,
   parameter int unsigned SCREEN_WIDTH  = tpm_pkg::ScreenWidthDef,
   parameter int unsigned SCREEN_HEIGHT = tpm_pkg::ScreenHeightDef
) (
   input  wire logic       device_present,
   input  wire logic       read_ok,
   input  wire logic [7:0] status_byte,
   input  wire logic [7:0] x_high,
   input  wire logic [7:0] x_low,
   input  wire logic [7:0] y_high,
   input  wire logic [7:0] y_low,
   output tpm_pkg::point_type point
);
   import tpm_pkg::*;

   localparam logic [RawWidth-1:0] NativeXMax = RawWidth'(NATIVE_WIDTH - 1);
   localparam logic [RawWidth-1:0] NativeYMax = RawWidth'(NATIVE_HEIGHT - 1);
   localparam logic [RawWidth-1:0] ScreenXMax = RawWidth'(SCREEN_WIDTH - 1);
   localparam logic [RawWidth-1:0] ScreenYMax = RawWidth'(SCREEN_HEIGHT - 1);

   logic [3:0]          count;
   logic [RawWidth-1:0] raw_x;
   logic [RawWidth-1:0] raw_y;
   logic [RawWidth-1:0] clamp_x;
   logic [RawWidth-1:0] clamp_y;
   logic [RawWidth-1:0] land_x;
   logic [RawWidth-1:0] land_y;

   always_comb begin
      count   = status_byte[3:0];
      raw_x   = {x_high[3:0], x_low};
      raw_y   = {y_high[3:0], y_low};
      clamp_x = (raw_x > NativeXMax) ? NativeXMax : raw_x;
      clamp_y = (raw_y > NativeYMax) ? NativeYMax : raw_y;
      // Portrait to landscape: x follows raw y, y runs against raw x.
      land_x  = (clamp_y > ScreenXMax) ? ScreenXMax : clamp_y;
      land_y  = NativeXMax - clamp_x;
      land_y  = (land_y > ScreenYMax) ? ScreenYMax : land_y;

      point.touched = device_present && read_ok &&
                      (count inside {[PointCountMin:PointCountMax]});
      point.x       = land_x[CoordWidth-1:0];
      point.y       = land_y[CoordWidth-1:0];
   end

endmodule

`default_nettype wire

[rtl/core/tpm_csr.sv]
// APB-style register file holding the press stretch length.
// Depends on tpm_pkg.
`default_nettype none

module tpm_csr (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            csr_psel,
   input  wire logic                            csr_penable,
   input  wire logic                            csr_pwrite,
   input  wire logic [tpm_pkg::CsrAddr-1:0]     csr_paddr,
   input  wire logic [tpm_pkg::CsrData-1:0]     csr_pwdata,
   output logic      [tpm_pkg::CsrData-1:0]     csr_prdata,
   output logic                                 csr_pready,
   output logic      [tpm_pkg::LatchWidth-1:0]  latch_polls
);
   import tpm_pkg::*;

   logic                  reg_index;
   logic                  write_en;
   logic [LatchWidth-1:0] latch_polls_ff;
   logic [LatchWidth-1:0] latch_polls_in;

   always_comb begin
      reg_index      = csr_paddr[CsrAddr-1];
      write_en       = csr_psel && csr_penable && csr_pwrite;
      latch_polls_in = latch_polls_ff;
      if (write_en && (reg_index == CsrIdxLatchPolls)) begin
         latch_polls_in = csr_pwdata[LatchWidth-1:0];
      end
      csr_prdata = '0;
      case (reg_index)
         CsrIdxLatchPolls: begin
            csr_prdata = CsrData'(latch_polls_ff);
         end
         default: begin
            csr_prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         latch_polls_ff <= LatchPollsReset;
      end else begin
         latch_polls_ff <= latch_polls_in;
      end
   end

   assign csr_pready  = 1'b1;
   assign latch_polls = latch_polls_ff;

endmodule

`default_nettype wire

[rtl/core/touch_point_mapper_with_press_latch.sv]
// Touch point mapper with press latch: top level.
// An accepted poll word passes stage one, then the result register; one word per cycle unless rsp_ready stalls.
// Stage one registers the poll word; stage two maps it, updates the press state and
// loads the result register. Reset clears the held point, the stretch counter, the press
// flag and both valid flags, and sets the stretch length to five polls.
// Depends on tpm_pkg, tpm_map and tpm_csr.
`default_nettype none

module touch_point_mapper_with_press_latch #(
   parameter int unsigned NATIVE_WIDTH  = tpm_pkg::NativeWidthDef,
   parameter int unsigned NATIVE_HEIGHT = tpm_pkg::NativeHeightDef,
   parameter int unsigned SCREEN_WIDTH  = tpm_pkg::ScreenWidthDef,
   parameter int unsigned SCREEN_HEIGHT = tpm_pkg::ScreenHeightDef
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   // Poll words in.
   input  wire logic                               req_valid,
   output logic                                    req_ready,
   input  wire logic                               req_device_present,
   input  wire logic                               req_read_ok,
   input  wire logic [7:0]                         req_status_byte,
   input  wire logic [7:0]                         req_x_high,
   input  wire logic [7:0]                         req_x_low,
   input  wire logic [7:0]                         req_y_high,
   input  wire logic [7:0]                         req_y_low,
   // Result words out.
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output logic                                    rsp_touch_pressed,
   output logic      [tpm_pkg::CoordWidth-1:0]     rsp_point_x,
   output logic      [tpm_pkg::CoordWidth-1:0]     rsp_point_y,
   output logic                                    rsp_click,
   // Configuration.
   input  wire logic                               csr_psel,
   input  wire logic                               csr_penable,
   input  wire logic                               csr_pwrite,
   input  wire logic [tpm_pkg::CsrAddr-1:0]        csr_paddr,
   input  wire logic [tpm_pkg::CsrData-1:0]        csr_pwdata,
   output logic      [tpm_pkg::CsrData-1:0]        csr_prdata,
   output logic                                    csr_pready
);
   import tpm_pkg::*;

   // Stage one: registered poll word.
   logic       s1_valid_ff, s1_valid_in;
   logic       s1_present_ff;
   logic       s1_ok_ff;
   logic [7:0] s1_status_ff;
   logic [7:0] s1_xh_ff, s1_xl_ff, s1_yh_ff, s1_yl_ff;

   // Press state carried from poll to poll.
   logic [CoordWidth-1:0] held_x_ff, held_x_in;
   logic [CoordWidth-1:0] held_y_ff, held_y_in;
   logic [LatchWidth-1:0] latch_count_ff, latch_count_in;
   logic                  press_seen_ff, press_seen_in;

   // Result register.
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  pressed_ff, pressed_in;
   logic                  click_ff, click_in;

   logic                  advance;
   logic                  take;
   logic [LatchWidth-1:0] latch_polls;
   point_type             point;

   tpm_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .latch_polls (latch_polls)
   );

   tpm_map #(
      .NATIVE_WIDTH  (NATIVE_WIDTH),
      .NATIVE_HEIGHT (NATIVE_HEIGHT),
      .SCREEN_WIDTH  (SCREEN_WIDTH),
      .SCREEN_HEIGHT (SCREEN_HEIGHT)
   ) u_map (
      .device_present (s1_present_ff),
      .read_ok        (s1_ok_ff),
      .status_byte    (s1_status_ff),
      .x_high         (s1_xh_ff),
      .x_low          (s1_xl_ff),
      .y_high         (s1_yh_ff),
      .y_low          (s1_yl_ff),
      .point          (point)
   );

   // The word in stage one moves on whenever the result register is empty or being
   // drained. While a result waits, stage one can still take one word, and the input
   // stalls only once both registers are full.
   assign advance   = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || advance;
   assign take      = req_valid && req_ready;

   always_comb begin
      s1_valid_in    = s1_valid_ff;
      rsp_valid_in   = rsp_valid_ff;
      held_x_in      = held_x_ff;
      held_y_in      = held_y_ff;
      latch_count_in = latch_count_ff;
      press_seen_in  = press_seen_ff;
      pressed_in     = pressed_ff;
      click_in       = 1'b0;

      if (take) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end

      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      // A real touch takes the new point and restarts the stretch. An empty poll
      // either burns one stretch poll or ends the press.
      if (point.touched) begin
         held_x_in      = point.x;
         held_y_in      = point.y;
         latch_count_in = latch_polls;
         pressed_in     = 1'b1;
         press_seen_in  = 1'b1;
         click_in       = !press_seen_ff;
      end else if (latch_count_ff != '0) begin
         latch_count_in = latch_count_ff - 1'b1;
         pressed_in     = 1'b1;
      end else begin
         pressed_in     = 1'b0;
         press_seen_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         held_x_ff      <= '0;
         held_y_ff      <= '0;
         latch_count_ff <= '0;
         press_seen_ff  <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            held_x_ff      <= held_x_in;
            held_y_ff      <= held_y_in;
            latch_count_ff <= latch_count_in;
            press_seen_ff  <= press_seen_in;
         end
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      if (take) begin
         s1_present_ff <= req_device_present;
         s1_ok_ff      <= req_read_ok;
         s1_status_ff  <= req_status_byte;
         s1_xh_ff      <= req_x_high;
         s1_xl_ff      <= req_x_low;
         s1_yh_ff      <= req_y_high;
         s1_yl_ff      <= req_y_low;
      end
      if (advance) begin
         pressed_ff <= pressed_in;
         click_ff   <= click_in;
      end
   end

   // The result word shows the point as held after this poll.
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_touch_pressed = pressed_ff;
   assign rsp_point_x       = held_x_ff;
   assign rsp_point_y       = held_y_ff;
   assign rsp_click         = click_ff;

   // A pending stretch always belongs to a press that has begun.
   assert property (@(posedge clock) disable iff (reset)
      (latch_count_ff != '0) |-> press_seen_ff)
      else $error("stretch counter running without a press");

   // A click is only ever reported together with a press.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && click_ff) |-> pressed_ff)
      else $error("click without press");

   // After a click the press flag is set.
   assert property (@(posedge clock) disable iff (reset)
      (advance && click_in) |=> press_seen_ff)
      else $error("press flag not set after click");

   // A stalled stage one must not take a new word.
   assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !advance) |-> !req_ready)
      else $error("input taken while stage one is stalled");

endmodule

`default_nettype wire
